FILE: hw/rtl/ivs_pkg.sv
// Package for the injection VC selector: request and result types, opcodes.
// No dependencies.
package ivs_pkg;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_INJECT = 1'b1
  } opcode_e;

  localparam logic [2:0] REG_BASE_VC  = 3'd0;
  localparam logic [2:0] REG_NUM_VCS  = 3'd1;
  localparam logic [2:0] REG_NUM_PORTS = 3'd2;
  localparam logic [2:0] REG_ADAPTIVE = 3'd3;
  localparam logic [2:0] REG_FIXED    = 3'd4;

  typedef struct packed {
    logic        opcode;
    logic [2:0]  port_index;
    logic [3:0]  vc_index;
    logic [15:0] occupancy_value;
    logic        first_of_message;
    logic [31:0] rand_primary;
    logic [31:0] rand_secondary;
  } ivs_req_t;

  typedef struct packed {
    logic [2:0] chosen_port;
    logic [3:0] chosen_vc;
  } ivs_res_t;

endpackage

FILE: hw/rtl/ivs_divu.sv
// Iterative 32-bit by 16-bit remainder unit, one quotient bit per cycle.
// Depends on nothing.
module ivs_divu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [15:0] rem_o
);
  logic [31:0] num_q, num_d;
  logic [16:0] rem_q, rem_d;
  logic [15:0] div_q, div_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [16:0] trial;

  // Load the operands on start; while busy, shift in one dividend bit and subtract when it fits
  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[15:0], num_q[31]};
    if (start_i) begin
      num_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[30:0], 1'b0};
      rem_d = (trial >= {1'b0, div_q}) ? trial - {1'b0, div_q} : trial;
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[15:0];
endmodule

FILE: hw/rtl/ivs_front.sv
// Front end: accepts requests into a two-entry queue toward the back end.
// Depends on ivs_pkg.
module ivs_front import ivs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  input  ivs_req_t req_i,
  output logic     full,
  output logic     valid_o,
  output ivs_req_t req_o,
  input  logic     take_i
);
  ivs_req_t   mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full    = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign req_o   = mem_q[rp_q];
  assign do_push = push && !full;
  assign do_pop  = take_i && valid_o;

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= req_i;
  end
endmodule

FILE: hw/rtl/ivs_back.sv
// Back end: occupancy table, adaptive scan, remainder picks, result register.
// Depends on ivs_pkg and ivs_divu.
module ivs_back import ivs_pkg::*; #(
  parameter int MAX_PORTS = 8,
  parameter int MAX_VCS   = 16,
  parameter int OCC_BITS  = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  ivs_req_t   req_i,
  output logic       take_o,
  input  logic [3:0] base_vc_i,
  input  logic [4:0] num_vcs_i,
  input  logic [3:0] num_ports_i,
  input  logic       adaptive_i,
  input  logic       fixed_i,
  output logic       empty,
  output ivs_res_t   res_o,
  input  logic       pop
);
  localparam int PW    = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
  localparam int VW    = (MAX_VCS > 1) ? $clog2(MAX_VCS) : 1;
  localparam int DEPTH = MAX_PORTS * MAX_VCS;
  localparam int AW    = PW + VW;
  localparam int CW    = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_SCAN, S_DRAIN, S_DIV1, S_DIV2, S_LOOK, S_OUT
  } state_e;

  state_e state_q;
  logic [OCC_BITS-1:0] occ_mem [DEPTH];
  logic [AW-1:0]       tie_mem [DEPTH];
  logic [OCC_BITS-1:0] rd_q, best_q;
  logic [AW-1:0]       clr_q, tie_q, rd_addr_q, scan_pv_q;
  logic [PW:0]         p_q;
  logic [VW:0]         v_q, vend_q;
  logic [CW-1:0]       cnt_q;
  logic                rd_vld_q, scan_done_q;
  logic [7:0]          np_q, nv_q;
  logic [VW:0]         vb_q;
  logic [31:0]         r2_q;
  logic [2:0]          port_q;
  logic [3:0]          vc_q;
  logic                full_q;
  logic [2:0]          held_port_q;
  logic [3:0]          held_vc_q;
  logic                held_valid_q;
  logic                div_start, div_done;
  logic [31:0]         div_num;
  logic [15:0]         div_den, div_rem;
  logic [VW:0]         vb_c;
  logic [VW+1:0]       nv_c, nv_lim;
  logic [PW:0]         np_c;
  logic                is_min;

  ivs_divu u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_num),
    .divisor_i(div_den), .done_o(div_done), .rem_o(div_rem)
  );

  // Clamp configuration
  always_comb begin
    vb_c = ({1'b0, base_vc_i} > 5'(MAX_VCS - 1)) ? (VW+1)'(MAX_VCS - 1)
         : (VW+1)'(base_vc_i);
    nv_lim = (VW+2)'(MAX_VCS) - (VW+2)'(vb_c);
    nv_c = (num_vcs_i == 5'd0) ? (VW+2)'(1) : (VW+2)'(num_vcs_i);
    if (nv_c > nv_lim) nv_c = nv_lim;
    np_c = (num_ports_i == 4'd0) ? (PW+1)'(1) : (PW+1)'(num_ports_i);
    if ({28'd0, num_ports_i} > 32'(MAX_PORTS)) np_c = (PW+1)'(MAX_PORTS);
  end

  assign take_o  = state_q == S_IDLE && valid_i && !full_q;
  assign empty   = !full_q;
  assign res_o   = '{chosen_port: port_q, chosen_vc: vc_q};
  assign is_min  = (cnt_q == '0) || (rd_q < best_q);
  assign div_start = (state_q == S_DRAIN && !rd_vld_q)
                  || (state_q == S_IDLE && take_o && req_i.opcode == OP_INJECT
                      && !(fixed_i && held_valid_q && !req_i.first_of_message)
                      && !adaptive_i)
                  || (state_q == S_DIV1 && div_done && !adaptive_i);
  always_comb begin
    div_num = req_i.rand_primary;
    div_den = 16'(np_c);
    if (state_q == S_DRAIN) begin
      div_num = r2_q; // rand_primary kept in r2_q for adaptive
      div_den = 16'(cnt_q);
    end else if (state_q == S_DIV1) begin
      div_num = r2_q;
      div_den = 16'(nv_q);
    end
  end

  // Memory ports
  always_ff @(posedge clk_i) begin
    if (state_q == S_CLEAR) occ_mem[clr_q] <= '0;
    else if (take_o && req_i.opcode == OP_UPDATE
             && {29'd0, req_i.port_index} < 32'(MAX_PORTS)
             && {28'd0, req_i.vc_index} < 32'(MAX_VCS))
      occ_mem[AW'(req_i.port_index) * AW'(MAX_VCS) + AW'(req_i.vc_index)]
        <= OCC_BITS'(req_i.occupancy_value);
    rd_q <= occ_mem[rd_addr_q];
    if (state_q == S_SCAN && rd_vld_q)
      tie_mem[is_min ? '0 : AW'(cnt_q)] <= scan_pv_q;
    tie_q <= tie_mem[AW'(div_rem)];
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      full_q <= 1'b0;
      held_valid_q <= 1'b0;
      held_port_q <= '0;
      held_vc_q <= '0;
      rd_vld_q <= 1'b0;
      scan_done_q <= 1'b0;
      cnt_q <= '0;
      best_q <= '0;
      p_q <= '0; v_q <= '0; vend_q <= '0; vb_q <= '0;
      np_q <= '0; nv_q <= '0; r2_q <= '0;
      rd_addr_q <= '0; port_q <= '0; vc_q <= '0; scan_pv_q <= '0;
    end else begin
      if (pop && full_q) full_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(DEPTH - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (take_o && req_i.opcode == OP_INJECT) begin
            if (fixed_i && held_valid_q && !req_i.first_of_message) begin
              port_q <= held_port_q;
              vc_q <= held_vc_q;
              full_q <= 1'b1;
            end else if (adaptive_i) begin
              r2_q <= req_i.rand_primary;
              p_q <= '0; v_q <= vb_c; vb_q <= vb_c;
              vend_q <= (VW+1)'(vb_c + (VW+1)'(nv_c) - (VW+1)'(1));
              np_q <= 8'(np_c);
              cnt_q <= '0;
              rd_addr_q <= AW'(vb_c);
              rd_vld_q <= 1'b0;
              scan_done_q <= 1'b0;
              state_q <= S_SCAN;
            end else begin
              r2_q <= req_i.rand_secondary;
              nv_q <= 8'(nv_c); vb_q <= vb_c;
              state_q <= S_DIV1;
            end
          end
        end
        S_SCAN: begin
          // Compare the previous read, issue the next
          if (rd_vld_q) begin
            if (is_min) begin best_q <= rd_q; cnt_q <= CW'(1); end
            else if (rd_q == best_q) cnt_q <= cnt_q + CW'(1);
          end
          scan_pv_q <= {p_q[PW-1:0], v_q[VW-1:0]};
          rd_vld_q <= !scan_done_q;
          if (!scan_done_q) begin
            if (v_q == vend_q) begin
              v_q <= vb_q;
              p_q <= p_q + (PW+1)'(1);
              if (8'(p_q) + 8'd1 == np_q) scan_done_q <= 1'b1;
              else rd_addr_q <= AW'(p_q + (PW+1)'(1)) * AW'(MAX_VCS) + AW'(vb_q);
            end else begin
              v_q <= v_q + (VW+1)'(1);
              rd_addr_q <= rd_addr_q + AW'(1);
            end
          end else state_q <= S_DRAIN;
        end
        S_DRAIN: state_q <= S_DIV2;
        S_DIV1: if (div_done) begin
          port_q <= 3'(div_rem);
          state_q <= S_DIV2;
        end
        S_DIV2: if (div_done) begin
          if (adaptive_i) state_q <= S_LOOK;
          else begin
            vc_q <= 4'(vb_q + (VW+1)'(div_rem));
            held_port_q <= port_q;
            held_vc_q <= 4'(vb_q + (VW+1)'(div_rem));
            held_valid_q <= 1'b1;
            full_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_LOOK: state_q <= S_OUT;
        S_OUT: begin
          port_q <= 3'(tie_q[AW-1:VW]);
          vc_q <= 4'(tie_q[VW-1:0]);
          held_port_q <= 3'(tie_q[AW-1:VW]);
          held_vc_q <= 4'(tie_q[VW-1:0]);
          held_valid_q <= 1'b1;
          full_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: hw/rtl/injection_vc_selector.sv
// Injection VC selector: picks a port and VC for each inject request.
// An update writes occupancy; a random pick takes two remainders (port,
// then VC); an adaptive pick scans the occupancy memory, one entry a
// cycle, then a remainder picks among the least-occupied entries.
// One request at a time. Reset clears the occupancy memory, no requests
// taken meanwhile; configuration returns to its reset values at once.
module injection_vc_selector import ivs_pkg::*; #(
  parameter int MAX_PORTS = 8,
  parameter int MAX_VCS   = 16,
  parameter int OCC_BITS  = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  input  ivs_req_t   req_i,
  output logic       full,
  output logic       empty,
  input  logic       pop,
  output ivs_res_t   res_o,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [4:0] cfg_data_i
);
  logic [3:0] base_vc_q, num_ports_q;
  logic [4:0] num_vcs_q;
  logic       adaptive_q, fixed_q, fvalid, take;
  ivs_req_t   freq;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_vc_q <= '0; num_vcs_q <= 5'd1; num_ports_q <= 4'd1;
      adaptive_q <= 1'b0; fixed_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BASE_VC:   base_vc_q <= cfg_data_i[3:0];
        REG_NUM_VCS:   num_vcs_q <= cfg_data_i;
        REG_NUM_PORTS: num_ports_q <= cfg_data_i[3:0];
        REG_ADAPTIVE:  adaptive_q <= cfg_data_i[0];
        REG_FIXED:     fixed_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  ivs_front u_front (
    .clk_i, .rst_ni, .push, .req_i, .full,
    .valid_o(fvalid), .req_o(freq), .take_i(take)
  );

  ivs_back #(.MAX_PORTS(MAX_PORTS), .MAX_VCS(MAX_VCS), .OCC_BITS(OCC_BITS)) u_back (
    .clk_i, .rst_ni, .valid_i(fvalid), .req_i(freq), .take_o(take),
    .base_vc_i(base_vc_q), .num_vcs_i(num_vcs_q), .num_ports_i(num_ports_q),
    .adaptive_i(adaptive_q), .fixed_i(fixed_q), .empty, .res_o, .pop
  );
endmodule
